// ----- rtl/crf_pkg.sv -----
// Shared types and constants for the circle raster framebuffer.
// No dependencies; every other file in rtl/ but crf_ram imports this package.
package crf_pkg;

  localparam int COORD_W    = 19;  // signed fixed point centre and radius
  localparam int CHAR_W     = 8;
  localparam int PIX_W      = 8;   // read position fields
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MUL_W      = COORD_W + 1;  // radius minus one step needs a bit more

  localparam int                DIM_RESET = 256;
  localparam logic [CHAR_W-1:0] BG_RESET  = 8'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_FILL    = 2'd1,
    CMD_OUTLINE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE       = 2'd0,
    STAT_BAD_RADIUS = 2'd1,
    STAT_OUTSIDE    = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SETUP,
    S_DRAW,
    S_READ,
    S_RESP
  } state_t;

  // Which square the shared multiplier produces during setup
  typedef enum logic [1:0] {
    SQ_CX,
    SQ_CY,
    SQ_R,
    SQ_INNER
  } sq_sel_t;

  typedef struct packed {
    logic    sq_en;
    sq_sel_t sq_sel;
    logic    col_step;
    logic    row_step;
  } crf_dist_ctl_t;

endpackage

// ----- rtl/crf_ifs.sv -----
// Valid/ready channel interfaces: command input, result output, register write.
// Depends on crf_pkg for field widths.
interface crf_in_if
  import crf_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] radius;
  logic [CHAR_W-1:0]         paint_char;
  logic [PIX_W-1:0]          pixel_col;
  logic [PIX_W-1:0]          pixel_row;

  modport source (output valid, command, center_x, center_y, radius, paint_char,
                  pixel_col, pixel_row, input ready);
  modport sink   (input valid, command, center_x, center_y, radius, paint_char,
                  pixel_col, pixel_row, output ready);
endinterface

interface crf_out_if
  import crf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [CHAR_W-1:0]  pixel_value;

  modport source (output valid, status, pixel_value, input ready);
  modport sink   (input valid, status, pixel_value, output ready);
endinterface

interface crf_cfg_if
  import crf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/circle_raster_framebuffer_top.sv -----
// Circle raster framebuffer: command sequencer, canvas RAM and distance tracker.
// Depends on crf_pkg, crf_ifs, crf_ram and crf_dist.
//
// Usage
//   cfg_chan : register writes (0 width, 1 height, 2 background char), always
//              ready; width and height are saturated into 1..MAX on write.
//              Write only while no command is in flight.
//   in_chan  : one command per transaction: clear, filled circle, outline
//              circle or read one cell. Ready only while the sequencer is idle.
//   out_chan : one result per command (status, pixel value).
// Steps from command transaction to result valid:
//   clear      all MAX_WIDTH*MAX_HEIGHT cells, one cell written per cycle
//   circle     4 setup squares through the shared multiplier, then one cell
//              per cycle over the canvas; a non-positive radius skips both
//   read       one registered RAM read; none when outside the canvas
// The RAM write port, one cell per cycle, sets the sweep time.
// A finished result sits in the output register; the next command is taken
// meanwhile, and its own result waits until the receiver takes the previous one.
// Reset returns the sequencer to idle and the registers to their defaults; the
// canvas contents are undefined until the first clear.
module circle_raster_framebuffer_top
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  crf_in_if.sink     in_chan,
  crf_out_if.source  out_chan,
  crf_cfg_if.sink    cfg_chan
);

  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int CMP_W   = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int XW      = DIM_W + PIX_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int W_RST   = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
  localparam int H_RST   = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                 input int maxv);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve == '0) begin
      return DIM_W'(1);
    end else if (ve > CMP_W'(maxv)) begin
      return DIM_W'(maxv);
    end
    return DIM_W'(ve);
  endfunction

  // Configuration registers
  logic [DIM_W-1:0]  width_r, height_r;
  logic [CHAR_W-1:0] bg_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(W_RST);
      height_r <= DIM_W'(H_RST);
      bg_r     <= BG_RESET;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        REG_WIDTH:  width_r  <= clamp_dim(cfg_chan.data, MAX_WIDTH);
        REG_HEIGHT: height_r <= clamp_dim(cfg_chan.data, MAX_HEIGHT);
        REG_BG:     bg_r     <= cfg_chan.data[CHAR_W-1:0];
        default:    bg_r     <= bg_r;
      endcase
    end
  end

  // Sequencer state
  state_t           state_r, state_nxt;
  sq_sel_t          sq_sel_r, sq_sel_nxt;
  logic [DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [AW-1:0]    addr_r, addr_nxt, rowbase_r, rowbase_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [CHAR_W-1:0] res_value_r, res_value_nxt;

  // Command fields held for the sweep
  logic signed [COORD_W-1:0] cx_r, cy_r, rad_r;
  logic                      outline_r;
  logic [CHAR_W-1:0]         paint_r;

  // Output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CHAR_W-1:0] out_value_r;
  logic              out_load;

  logic              in_acc;
  logic              outside;
  logic [AW-1:0]     rd_addr_in;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;
  crf_dist_ctl_t     dctl;
  logic              covered;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign outside = (XW'(in_chan.pixel_col) >= XW'(width_r)) ||
                   (XW'(in_chan.pixel_row) >= XW'(height_r));
  assign rd_addr_in = AW'(AW'(in_chan.pixel_row) * AW'(MAX_WIDTH)) +
                      AW'(in_chan.pixel_col);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r      <= in_chan.center_x;
      cy_r      <= in_chan.center_y;
      rad_r     <= in_chan.radius;
      outline_r <= (cmd_t'(in_chan.command) == CMD_OUTLINE);
      paint_r   <= in_chan.paint_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sq_sel_r     <= sq_sel_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    addr_r       <= addr_nxt;
    rowbase_r    <= rowbase_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    sq_sel_nxt     = sq_sel_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    addr_nxt       = addr_r;
    rowbase_nxt    = rowbase_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = paint_r;
    ram_re         = 1'b0;
    out_load       = 1'b0;
    dctl           = '{sq_en: 1'b0, sq_sel: sq_sel_r, col_step: 1'b0, row_step: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = STAT_DONE;
          res_value_nxt  = '0;
          col_nxt        = '0;
          row_nxt        = '0;
          addr_nxt       = '0;
          rowbase_nxt    = '0;
          sq_sel_nxt     = SQ_CX;
          unique case (cmd_t'(in_chan.command))
            CMD_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            CMD_FILL, CMD_OUTLINE: begin
              if (in_chan.radius <= $signed(COORD_W'(0))) begin
                res_status_nxt = STAT_BAD_RADIUS;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_SETUP;
              end
            end
            CMD_READ: begin
              if (outside) begin
                res_status_nxt = STAT_OUTSIDE;
                state_nxt      = S_RESP;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = bg_r;
        addr_nxt  = addr_r + AW'(1);
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_RESP;
        end
      end
      S_SETUP: begin
        dctl.sq_en = 1'b1;
        unique case (sq_sel_r)
          SQ_CX:    sq_sel_nxt = SQ_CY;
          SQ_CY:    sq_sel_nxt = SQ_R;
          SQ_R:     sq_sel_nxt = SQ_INNER;
          SQ_INNER: state_nxt  = S_DRAW;
          default:  state_nxt  = S_DRAW;
        endcase
      end
      S_DRAW: begin
        ram_we = covered;
        if (col_r == width_r - DIM_W'(1)) begin
          if (row_r == height_r - DIM_W'(1)) begin
            state_nxt = S_RESP;
          end else begin
            dctl.row_step = 1'b1;
            col_nxt       = '0;
            row_nxt       = row_r + DIM_W'(1);
            rowbase_nxt   = rowbase_r + AW'(MAX_WIDTH);
            addr_nxt      = rowbase_r + AW'(MAX_WIDTH);
          end
        end else begin
          dctl.col_step = 1'b1;
          col_nxt       = col_r + DIM_W'(1);
          addr_nxt      = addr_r + AW'(1);
        end
      end
      S_READ: begin
        res_value_nxt = ram_rdata;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.pixel_value = out_value_r;

  crf_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_addr_in),
    .rdata (ram_rdata)
  );

  crf_dist #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dist (
    .clk     (clk),
    .ctl     (dctl),
    .cx      (cx_r),
    .cy      (cy_r),
    .r       (rad_r),
    .outline (outline_r),
    .covered (covered)
  );

`ifndef SYNTHESIS
  a_we_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_DRAW))
    else $error("canvas written outside a sweep");

  a_draw_in_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW) |-> (col_r < width_r && row_r < height_r))
    else $error("draw position beyond canvas");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not presented after response");

  a_read_follows_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ($past(state_r) == S_IDLE && $past(ram_re)))
    else $error("read data used without a read request");
`endif

endmodule

// ----- rtl/crf_ram.sv -----
// Generic single-clock RAM, one write port and one read port, registered read.
// No package dependency.
module crf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/crf_dist.sv -----
// Squared distance tracker for the raster sweep: squares set up through one
// shared multiplier, then stepped per column and per row by adds only.
// Depends on crf_pkg.
module crf_dist
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic                      clk,
  input  crf_dist_ctl_t             ctl,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic signed [COORD_W-1:0] r,
  input  logic                      outline,
  output logic                      covered
);

  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int PW      = DIM_W + FRAC_BITS;
  localparam int DW      = ((PW > COORD_W - 1) ? PW : COORD_W - 1) + 2;
  localparam int SQW     = 2 * DW;

  localparam logic signed [MUL_W-1:0] STEP_M  = MUL_W'(1) << FRAC_BITS;
  localparam logic signed [DW-1:0]    STEP_D  = DW'(1) << FRAC_BITS;
  localparam logic signed [SQW-1:0]   STEP_SQ = SQW'(1) << (2 * FRAC_BITS);

  logic signed [DW-1:0]      dx_r, dy_r;
  logic signed [SQW-1:0]     dx2_r, dy2_r, cx2_r, r2_r, inner2_r;
  logic                      inner_pos_r;

  logic signed [MUL_W-1:0]   inner_w;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [2*MUL_W-1:0] prod;
  logic signed [SQW-1:0]     prod_ext;
  logic signed [DW-1:0]      ncx, ncy;
  logic signed [SQW-1:0]     dx_term, dy_term;
  logic signed [SQW-1:0]     d2;

  assign inner_w = $signed({r[COORD_W-1], r}) - STEP_M;
  assign ncx = DW'(0) - $signed({{(DW-COORD_W){cx[COORD_W-1]}}, cx});
  assign ncy = DW'(0) - $signed({{(DW-COORD_W){cy[COORD_W-1]}}, cy});

  always_comb begin
    unique case (ctl.sq_sel)
      SQ_CX:    mul_a = $signed({cx[COORD_W-1], cx});
      SQ_CY:    mul_a = $signed({cy[COORD_W-1], cy});
      SQ_R:     mul_a = $signed({r[COORD_W-1], r});
      SQ_INNER: mul_a = inner_w;
      default:  mul_a = '0;
    endcase
  end

  assign prod     = mul_a * mul_a;
  assign prod_ext = SQW'(prod);

  // (d + S)^2 = d^2 + 2*S*d + S^2
  assign dx_term = $signed({{(SQW-DW){dx_r[DW-1]}}, dx_r}) <<< (FRAC_BITS + 1);
  assign dy_term = $signed({{(SQW-DW){dy_r[DW-1]}}, dy_r}) <<< (FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      unique case (ctl.sq_sel)
        SQ_CX: begin
          cx2_r <= prod_ext;
          dx2_r <= prod_ext;
          dx_r  <= ncx;
        end
        SQ_CY: begin
          dy2_r <= prod_ext;
          dy_r  <= ncy;
        end
        SQ_R: begin
          r2_r <= prod_ext;
        end
        SQ_INNER: begin
          inner2_r    <= prod_ext;
          inner_pos_r <= ~inner_w[MUL_W-1];
        end
        default: begin
          inner_pos_r <= inner_pos_r;
        end
      endcase
    end else if (ctl.row_step) begin
      dy2_r <= dy2_r + dy_term + STEP_SQ;
      dy_r  <= dy_r + STEP_D;
      dx2_r <= cx2_r;
      dx_r  <= ncx;
    end else if (ctl.col_step) begin
      dx2_r <= dx2_r + dx_term + STEP_SQ;
      dx_r  <= dx_r + STEP_D;
    end
  end

  assign d2      = dx2_r + dy2_r;
  assign covered = (d2 <= r2_r) && !(outline && inner_pos_r && (d2 <= inner2_r));

endmodule

// ----- tb/sv/crf_checker.sv -----
// Scoreboard for the circle raster framebuffer: mirrors the canvas and registers.
// Watches the cfg, command and result channels; depends on crf_pkg and crf_ifs.
module crf_checker
  import crf_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 8
) (
  input  logic clk,
  input  logic rst_n,
  crf_in_if    in_mon,
  crf_out_if   out_mon,
  crf_cfg_if   cfg_mon,
  output int   mismatches,
  output int   outstanding,
  output int   answers_checked
);

  typedef struct packed {
    status_t           status;
    logic [CHAR_W-1:0] pixel_value;
  } answer_t;

  logic [CHAR_W-1:0] canvas_mirror [MAX_WIDTH*MAX_HEIGHT];
  int unsigned       cols_in_use;
  int unsigned       rows_in_use;
  logic [CHAR_W-1:0] bg_char;
  answer_t           awaited_answers [$];

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    answers_checked = 0;
  end

  function automatic int unsigned saturate_dim(logic [CFG_DATA_W-1:0] raw, int unsigned limit);
    if (raw == '0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void sweep_circle(longint cx, longint cy, longint rad, bit hollow,
                                       logic [CHAR_W-1:0] ch);
    longint outer_sq, inner, inner_sq, dx, dy, dist_sq;
    outer_sq = rad * rad;
    inner    = rad - (longint'(1) <<< FRAC_BITS);
    inner_sq = inner * inner;
    for (int unsigned y = 0; y < rows_in_use; y++) begin
      dy = (longint'(y) <<< FRAC_BITS) - cy;
      for (int unsigned x = 0; x < cols_in_use; x++) begin
        dx      = (longint'(x) <<< FRAC_BITS) - cx;
        dist_sq = dx * dx + dy * dy;
        // outline: a negative inner radius leaves the whole disc covered
        if (dist_sq <= outer_sq && !(hollow && inner >= 0 && dist_sq <= inner_sq))
          canvas_mirror[y * MAX_WIDTH + x] = ch;
      end
    end
  endfunction

  function automatic answer_t run_command(cmd_t op, logic signed [COORD_W-1:0] cx,
                                          logic signed [COORD_W-1:0] cy,
                                          logic signed [COORD_W-1:0] rad,
                                          logic [CHAR_W-1:0] ch,
                                          logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    answer_t ans;
    ans.status      = STAT_DONE;
    ans.pixel_value = '0;
    case (op)
      CMD_CLEAR: begin
        foreach (canvas_mirror[i]) canvas_mirror[i] = bg_char;
      end
      CMD_FILL, CMD_OUTLINE: begin
        if (rad <= 0) ans.status = STAT_BAD_RADIUS;
        else sweep_circle(cx, cy, rad, op == CMD_OUTLINE, ch);
      end
      default: begin
        if (col >= cols_in_use || row >= rows_in_use) ans.status = STAT_OUTSIDE;
        else ans.pixel_value = canvas_mirror[row * MAX_WIDTH + col];
      end
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      cols_in_use = saturate_dim(CFG_DATA_W'(DIM_RESET), MAX_WIDTH);
      rows_in_use = saturate_dim(CFG_DATA_W'(DIM_RESET), MAX_HEIGHT);
      bg_char     = BG_RESET;
      awaited_answers.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_WIDTH:  cols_in_use = saturate_dim(cfg_mon.data, MAX_WIDTH);
          REG_HEIGHT: rows_in_use = saturate_dim(cfg_mon.data, MAX_HEIGHT);
          REG_BG:     bg_char = cfg_mon.data[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        awaited_answers.push_back(run_command(cmd_t'(in_mon.command), in_mon.center_x,
                                              in_mon.center_y, in_mon.radius,
                                              in_mon.paint_char, in_mon.pixel_col,
                                              in_mon.pixel_row));
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_answers.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result transaction: status %0d value 0x%02h", $time,
                   out_mon.status, out_mon.pixel_value);
        end else begin
          want = awaited_answers.pop_front();
          answers_checked++;
          if (out_mon.status !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, out_mon.status);
          end
          if (out_mon.pixel_value !== want.pixel_value) begin
            mismatches++;
            $display("%0t: pixel_value mismatch: expected 0x%02h actual 0x%02h", $time,
                     want.pixel_value, out_mon.pixel_value);
          end
        end
      end
    end
    outstanding = awaited_answers.size();
  end

endmodule

// ----- tb/sv/circle_raster_framebuffer_top_tb.sv -----
// Top-level bench for circle_raster_framebuffer_top: clock, reset, stimulus, verdict.
// Depends on crf_pkg, crf_ifs, the RTL and crf_checker, which checks every result.
module circle_raster_framebuffer_top_tb;
  import crf_pkg::*;

  localparam int MAX_W       = 256;
  localparam int MAX_H       = 256;
  localparam int FRAC        = 8;
  localparam int ONE         = 1 << FRAC;
  localparam int QUIET_LIMIT = 4 * (MAX_W * MAX_H + 64);
  localparam int DRAIN       = 16;

  logic clk;
  logic rst_n;

  crf_in_if  in_chan ();
  crf_out_if out_chan ();
  crf_cfg_if cfg_chan ();

  int mismatches;
  int outstanding;
  int answers_checked;

  int send_idle_pct;
  int recv_idle_pct;
  int cur_w;
  int cur_h;
  int clears_left;
  int settings_used;
  int cmd_tally [4];
  int quiet_cycles;

  circle_raster_framebuffer_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS (FRAC)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  crf_checker #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H),
    .FRAC_BITS (FRAC)
  ) canvas_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .cfg_mon        (cfg_chan),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .answers_checked(answers_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= rst_n && (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  // nothing accepted on any channel for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered at a falling edge; valid from the previous transaction is only lowered on a gap
  task automatic send_cmd(cmd_t op, int cx, int cy, int rad, int ch, int col, int row);
    if (int'($urandom_range(99)) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(negedge clk); while (int'($urandom_range(99)) < send_idle_pct);
    end
    in_chan.valid      <= 1'b1;
    in_chan.command    <= op;
    in_chan.center_x   <= cx[COORD_W-1:0];
    in_chan.center_y   <= cy[COORD_W-1:0];
    in_chan.radius     <= rad[COORD_W-1:0];
    in_chan.paint_char <= ch[CHAR_W-1:0];
    in_chan.pixel_col  <= col[PIX_W-1:0];
    in_chan.pixel_row  <= row[PIX_W-1:0];
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    cmd_tally[op]++;
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_registers(int w_raw, int h_raw, int bg);
    int vals [3];
    vals[0] = w_raw;
    vals[1] = h_raw;
    vals[2] = bg;
    for (int i = 0; i < 3; i++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= CFG_IDX_W'(i);
      cfg_chan.data  <= vals[i][CFG_DATA_W-1:0];
      do @(posedge clk); while (!cfg_chan.ready);
      @(negedge clk);
    end
    cfg_chan.valid <= 1'b0;
    w_raw = w_raw & 9'h1ff;
    h_raw = h_raw & 9'h1ff;
    cur_w = (w_raw == 0) ? 1 : ((w_raw > MAX_W) ? MAX_W : w_raw);
    cur_h = (h_raw == 0) ? 1 : ((h_raw > MAX_H) ? MAX_H : h_raw);
    settings_used++;
  endtask

  task automatic random_item();
    int   pick, dim, cx, cy, rad, col, row;
    cmd_t op;
    pick = $urandom_range(99);
    if (pick < 3 && clears_left > 0) begin
      op = CMD_CLEAR;
      clears_left--;
    end else if (pick < 30) op = CMD_FILL;
    else if (pick < 57) op = CMD_OUTLINE;
    else op = CMD_READ;
    dim = (cur_w > cur_h) ? cur_w : cur_h;
    // centres mostly on or near the canvas, with a fractional part
    if ($urandom_range(9) == 0) cx = $urandom;
    else cx = (int'($urandom_range(cur_w + 3)) - 2) * ONE + int'($urandom_range(ONE - 1));
    if ($urandom_range(9) == 0) cy = $urandom;
    else cy = (int'($urandom_range(cur_h + 3)) - 2) * ONE + int'($urandom_range(ONE - 1));
    case ($urandom_range(9))
      0:       rad = $urandom;
      1:       rad = -int'($urandom_range(3 * ONE));
      2:       rad = $urandom_range(2 * ONE);
      default: rad = $urandom_range((dim / 2 + 2) * ONE);
    endcase
    if ($urandom_range(4) == 0) col = $urandom_range(255);
    else col = $urandom_range(cur_w + 1);
    if ($urandom_range(4) == 0) row = $urandom_range(255);
    else row = $urandom_range(cur_h + 1);
    send_cmd(op, cx, cy, rad, $urandom_range(255), col, row);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.command    = CMD_CLEAR;
    in_chan.center_x   = '0;
    in_chan.center_y   = '0;
    in_chan.radius     = '0;
    in_chan.paint_char = '0;
    in_chan.pixel_col  = '0;
    in_chan.pixel_row  = '0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = REG_WIDTH;
    cfg_chan.data      = '0;
    send_idle_pct      = 15;
    recv_idle_pct      = 57;
    cur_w              = MAX_W;
    cur_h              = MAX_H;
    clears_left        = 3;
    settings_used      = 1;
    quiet_cycles       = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset register values, full canvas first
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 255, 255);
    send_cmd(CMD_FILL, 128 * ONE, 100 * ONE + 77, 40 * ONE + 200, "C", 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 128, 100);

    wait_idle();
    write_registers(16, 10, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 15, 9);
    send_cmd(CMD_FILL, -262144, -262144, 262143, 255, 0, 0);
    // corner cell lies exactly on the rim
    send_cmd(CMD_FILL, 262143, 0, 262143, 8'h5a, 0, 0);
    send_cmd(CMD_OUTLINE, 3 * ONE, 3 * ONE, 1, "c", 0, 0);
    // inner radius of zero drops only the centre cell
    send_cmd(CMD_OUTLINE, 8 * ONE, 5 * ONE, ONE, "o", 0, 0);
    send_cmd(CMD_OUTLINE, 8 * ONE + 128, 4 * ONE + 128, 4 * ONE + 100, 0, 0, 0);
    send_cmd(CMD_OUTLINE, 0, 0, 262143, 8'ha5, 0, 0);
    send_cmd(CMD_FILL, 5 * ONE, 5 * ONE, 0, 8'h11, 0, 0);
    send_cmd(CMD_OUTLINE, 5 * ONE, 5 * ONE, -1, 8'h22, 0, 0);
    send_cmd(CMD_FILL, 5 * ONE, 5 * ONE, -262144, 8'h33, 0, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 8, 5);
    send_cmd(CMD_READ, 0, 0, 0, 0, 9, 5);
    send_cmd(CMD_READ, 0, 0, 0, 0, 3, 3);
    send_cmd(CMD_READ, 0, 0, 0, 0, 12, 4);
    send_cmd(CMD_READ, 0, 0, 0, 0, 16, 0);
    send_cmd(CMD_READ, 0, 0, 0, 0, 0, 10);
    send_cmd(CMD_READ, 0, 0, 0, 0, 255, 255);
    send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      if (phase < 2) begin
        send_idle_pct = 15;
        recv_idle_pct = 57;
      end else if (phase < 4) begin
        send_idle_pct = 57;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0:       write_registers(1, 1, 255);
        2:       write_registers(256, 2, $urandom_range(255));
        3:       write_registers(0, 511, $urandom_range(255));
        4:       write_registers(511, 0, $urandom_range(255));
        default: write_registers($urandom_range(2, 24), $urandom_range(2, 24),
                                 $urandom_range(255));
      endcase
      repeat (13) random_item();
    end

    wait_idle();
    repeat (DRAIN) @(negedge clk);
    $display("Sent %0d commands: %0d clear, %0d filled, %0d outline, %0d read, %0d settings",
             cmd_tally[CMD_CLEAR] + cmd_tally[CMD_FILL] + cmd_tally[CMD_OUTLINE] +
             cmd_tally[CMD_READ], cmd_tally[CMD_CLEAR], cmd_tally[CMD_FILL],
             cmd_tally[CMD_OUTLINE], cmd_tally[CMD_READ], settings_used);
    $display("Results checked: %0d, mismatches: %0d", answers_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
